// ===== design/sfd_pkg.sv =====
package sfd_pkg;

  // default store size and fixed frame layout
  localparam int unsigned StoreBytes  = 256;
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned ShadowBytes = 6;
  localparam logic [15:0] LoopMark    = 16'hEEEE;

  // configuration register index width, two spare codes left unused
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE = 2'd0,
    CFG_PAD_BYTE   = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    CMD_RX = 1'b0,
    CMD_TX = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    RXEV_NONE     = 3'd0,
    RXEV_DROPPED  = 3'd1,
    RXEV_RESYNC   = 3'd2,
    RXEV_CSUM     = 3'd3,
    RXEV_HDR_OK   = 3'd4,
    RXEV_COMPLETE = 3'd5,
    RXEV_OVERFLOW = 3'd6
  } rx_event_e;

  typedef enum logic [1:0] {
    LOOP_NONE    = 2'd0,
    LOOP_STARTED = 2'd1,
    LOOP_REFUSED = 2'd2
  } loop_event_e;

endpackage

// ===== design/sfd_if.sv =====
// input item channel
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source(output valid, output cmd, output rx_byte, input ready);
  modport sink(input valid, input cmd, input rx_byte, output ready);
endinterface

// result channel
interface sfd_out_if #(
  parameter int unsigned CntW = 9
);
  logic            valid;
  logic            ready;
  logic [7:0]      tx_byte;
  logic            tx_from_store;
  logic            tx_done;
  logic [2:0]      rx_event;
  logic [CntW-1:0] rx_fill;
  logic [1:0]      loop_event;

  modport source(output valid, output tx_byte, output tx_from_store, output tx_done,
                 output rx_event, output rx_fill, output loop_event, input ready);
  modport sink(input valid, input tx_byte, input tx_from_store, input tx_done,
               input rx_event, input rx_fill, input loop_event, output ready);
endinterface

// configuration write channel
interface sfd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sfd_pkg::CfgIdxW-1:0] index;
  logic [7:0]                 data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== design/spi_frame_deframer_loopback.sv =====
// SPI frame deframer with loopback
//
// in_i carries one beat per SPI event: cmd = 0 delivers a received byte,
// cmd = 1 announces a free transmit slot. Every input beat gives exactly one
// result beat on out_o. cfg_i writes start_byte (index 0) and pad_byte
// (index 1); other indexes are ignored, and cfg_i is always ready.
//
// A received byte is answered from the output register in the cycle after it
// is accepted; a transmit slot that sends stored data goes through the
// registered read of the transmit memory first. One item is in flight at a time.
// A frame that starts a loopback is copied from the receive memory to the
// transmit memory one byte per cycle via the receive memory's read port, and
// no new beat is taken until the last byte is written and the sweep is idle.
//
// Reset clears the phase, counters and registers; both 8-bit memories hold
// no reset value and need no clearing pass. When the result receiver stalls,
// the result waits in the output register and no new beat is accepted until
// it is taken (a beat can be accepted in the cycle the old one leaves).
module spi_frame_deframer_loopback #(
  parameter int unsigned STORE_BYTES = sfd_pkg::StoreBytes
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_in_if.sink       in_i,
  sfd_out_if.source    out_o,
  sfd_cfg_if.sink      cfg_i
);

  localparam int unsigned CntW  = $clog2(STORE_BYTES + 1);
  localparam int unsigned AddrW = $clog2(STORE_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TXRD,
    S_COPY
  } state_e;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_BODY
  } phase_e;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  rx_count_q, rx_count_d;
  logic [CntW-1:0]  tx_count_q, tx_count_d;
  logic [CntW-1:0]  tx_length_q, tx_length_d;
  logic [CntW-1:0]  copy_rd_q, copy_rd_d;
  logic [AddrW-1:0] copy_wa_q, copy_wa_d;
  logic             copy_wv_q, copy_wv_d;
  logic [7:0]       start_q, start_d;
  logic [7:0]       pad_q, pad_d;

  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_tx_byte_q, out_tx_byte_d;
  logic             out_from_q, out_from_d;
  logic             out_done_q, out_done_d;
  logic [2:0]       out_rx_event_q, out_rx_event_d;
  logic [CntW-1:0]  out_rx_fill_q, out_rx_fill_d;
  logic [1:0]       out_loop_q, out_loop_d;

  // shadow of the first frame bytes, mirrors the receive memory
  logic [7:0]       shadow_q [sfd_pkg::ShadowBytes];
  logic [7:0]       view     [sfd_pkg::ShadowBytes];

  logic [7:0]       rx_mem [STORE_BYTES];
  logic [7:0]       tx_mem [STORE_BYTES];
  logic [7:0]       rx_rdata_q;
  logic [7:0]       tx_rdata_q;

  logic             in_acc;
  logic             rx_full;
  logic             rx_we;
  logic             rx_re;
  logic             tx_re;
  logic [CntW-1:0]  cnt_inc;
  logic [15:0]      frame_len;
  logic [15:0]      frame_mark;
  logic             tx_busy;

  assign in_i.ready  = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;

  assign rx_full = (rx_count_q >= CntW'(STORE_BYTES));
  assign rx_we   = in_acc && (in_i.cmd == sfd_pkg::CMD_RX) && !rx_full;
  assign cnt_inc = rx_count_q + CntW'(1);
  assign tx_busy = (tx_count_q < tx_length_q);

  // header bytes as they stand once this beat is written
  always_comb begin
    for (int i = 0; i < int'(sfd_pkg::ShadowBytes); i++) begin
      view[i] = (rx_count_q == CntW'(i)) ? in_i.rx_byte : shadow_q[i];
    end
  end

  assign frame_len  = {view[3], view[2]};
  assign frame_mark = {view[5], view[4]};

  // copy sweep reads the receive memory, slot beats read the transmit memory
  assign rx_re = (state_q == S_COPY) && (copy_rd_q < tx_length_q);
  assign tx_re = in_acc && (in_i.cmd == sfd_pkg::CMD_TX) && tx_busy;

  // next-state logic
  always_comb begin
    state_d        = state_q;
    phase_d        = phase_q;
    rx_count_d     = rx_count_q;
    tx_count_d     = tx_count_q;
    tx_length_d    = tx_length_q;
    copy_rd_d      = copy_rd_q;
    copy_wa_d      = copy_wa_q;
    copy_wv_d      = 1'b0;
    start_d        = start_q;
    pad_d          = pad_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_tx_byte_d  = out_tx_byte_q;
    out_from_d     = out_from_q;
    out_done_d     = out_done_q;
    out_rx_event_d = out_rx_event_q;
    out_rx_fill_d  = out_rx_fill_q;
    out_loop_d     = out_loop_q;

    // configuration writes
    if (cfg_i.valid) begin
      if (cfg_i.index == sfd_pkg::CFG_START_BYTE) begin
        start_d = cfg_i.data;
      end else if (cfg_i.index == sfd_pkg::CFG_PAD_BYTE) begin
        pad_d = cfg_i.data;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.cmd == sfd_pkg::CMD_RX)) begin
          // received byte
          out_valid_d    = 1'b1;
          out_tx_byte_d  = 8'd0;
          out_from_d     = 1'b0;
          out_done_d     = 1'b0;
          out_rx_event_d = sfd_pkg::RXEV_NONE;
          out_loop_d     = sfd_pkg::LOOP_NONE;
          if (rx_full) begin
            out_rx_event_d = sfd_pkg::RXEV_DROPPED;
          end else begin
            rx_count_d = cnt_inc;
            case (phase_q)
              PH_HUNT: begin
                if (view[0] != start_q) begin
                  rx_count_d     = '0;
                  out_rx_event_d = sfd_pkg::RXEV_RESYNC;
                end else begin
                  phase_d = PH_HEAD;
                end
              end
              PH_HEAD: begin
                if (cnt_inc == CntW'(sfd_pkg::HeaderBytes)) begin
                  if ((view[0] ^ view[2] ^ view[3]) != view[1]) begin
                    rx_count_d     = '0;
                    phase_d        = PH_HUNT;
                    out_rx_event_d = sfd_pkg::RXEV_CSUM;
                  end else begin
                    phase_d        = PH_BODY;
                    out_rx_event_d = sfd_pkg::RXEV_HDR_OK;
                  end
                end else if (cnt_inc > CntW'(sfd_pkg::HeaderBytes)) begin
                  rx_count_d     = '0;
                  phase_d        = PH_HUNT;
                  out_rx_event_d = sfd_pkg::RXEV_OVERFLOW;
                end
              end
              PH_BODY: begin
                if (16'(cnt_inc) == frame_len) begin
                  rx_count_d     = '0;
                  phase_d        = PH_HUNT;
                  out_rx_event_d = sfd_pkg::RXEV_COMPLETE;
                  if (frame_mark == sfd_pkg::LoopMark) begin
                    if (tx_busy) begin
                      out_loop_d = sfd_pkg::LOOP_REFUSED;
                    end else begin
                      // frame length equals the count here, always within the store
                      out_loop_d  = sfd_pkg::LOOP_STARTED;
                      tx_count_d  = '0;
                      tx_length_d = cnt_inc;
                      copy_rd_d   = '0;
                      state_d     = S_COPY;
                    end
                  end
                end else if (cnt_inc >= CntW'(STORE_BYTES)) begin
                  rx_count_d     = '0;
                  phase_d        = PH_HUNT;
                  out_rx_event_d = sfd_pkg::RXEV_OVERFLOW;
                end
              end
              default: begin
                rx_count_d = '0;
                phase_d    = PH_HUNT;
              end
            endcase
          end
          out_rx_fill_d = rx_count_d;
        end else if (in_acc) begin
          // transmit slot
          if (tx_busy) begin
            tx_count_d = tx_count_q + CntW'(1);
            state_d    = S_TXRD;
          end else begin
            out_valid_d    = 1'b1;
            out_tx_byte_d  = pad_q;
            out_from_d     = 1'b0;
            out_done_d     = 1'b1;
            out_rx_event_d = sfd_pkg::RXEV_NONE;
            out_rx_fill_d  = rx_count_q;
            out_loop_d     = sfd_pkg::LOOP_NONE;
          end
        end
      end
      S_TXRD: begin
        // stored byte arrives from the transmit memory
        out_valid_d    = 1'b1;
        out_tx_byte_d  = tx_rdata_q;
        out_from_d     = 1'b1;
        out_done_d     = (tx_count_q == tx_length_q);
        out_rx_event_d = sfd_pkg::RXEV_NONE;
        out_rx_fill_d  = rx_count_q;
        out_loop_d     = sfd_pkg::LOOP_NONE;
        state_d        = S_IDLE;
      end
      S_COPY: begin
        // read one byte, write the previous one
        if (rx_re) begin
          copy_rd_d = copy_rd_q + CntW'(1);
          copy_wa_d = copy_rd_q[AddrW-1:0];
          copy_wv_d = 1'b1;
        end else if (!copy_wv_q) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_q        <= PH_HUNT;
      rx_count_q     <= '0;
      tx_count_q     <= '0;
      tx_length_q    <= '0;
      copy_rd_q      <= '0;
      copy_wa_q      <= '0;
      copy_wv_q      <= 1'b0;
      start_q        <= 8'd0;
      pad_q          <= 8'd0;
      out_valid_q    <= 1'b0;
      out_tx_byte_q  <= 8'd0;
      out_from_q     <= 1'b0;
      out_done_q     <= 1'b0;
      out_rx_event_q <= sfd_pkg::RXEV_NONE;
      out_rx_fill_q  <= '0;
      out_loop_q     <= sfd_pkg::LOOP_NONE;
    end else begin
      state_q        <= state_d;
      phase_q        <= phase_d;
      rx_count_q     <= rx_count_d;
      tx_count_q     <= tx_count_d;
      tx_length_q    <= tx_length_d;
      copy_rd_q      <= copy_rd_d;
      copy_wa_q      <= copy_wa_d;
      copy_wv_q      <= copy_wv_d;
      start_q        <= start_d;
      pad_q          <= pad_d;
      out_valid_q    <= out_valid_d;
      out_tx_byte_q  <= out_tx_byte_d;
      out_from_q     <= out_from_d;
      out_done_q     <= out_done_d;
      out_rx_event_q <= out_rx_event_d;
      out_rx_fill_q  <= out_rx_fill_d;
      out_loop_q     <= out_loop_d;
    end
  end

  // header shadow follows writes to the first bytes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(sfd_pkg::ShadowBytes); i++) begin
      if (rx_we && (rx_count_q == CntW'(i))) begin
        shadow_q[i] <= in_i.rx_byte;
      end
    end
  end

  // receive memory, one write and one read port
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_count_q[AddrW-1:0]] <= in_i.rx_byte;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[copy_rd_q[AddrW-1:0]];
    end
  end

  // transmit memory, filled by the copy sweep
  always_ff @(posedge clk_i) begin
    if (copy_wv_q) begin
      tx_mem[copy_wa_q] <= rx_rdata_q;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_count_q[AddrW-1:0]];
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.tx_byte       = out_tx_byte_q;
  assign out_o.tx_from_store = out_from_q;
  assign out_o.tx_done       = out_done_q;
  assign out_o.rx_event      = out_rx_event_q;
  assign out_o.rx_fill       = out_rx_fill_q;
  assign out_o.loop_event    = out_loop_q;

`ifndef NO_ASSERTIONS
  a_tx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_count_q <= tx_length_q)
    else $error("transmit count passed transmit length");

  a_rx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_count_q <= CntW'(STORE_BYTES))
    else $error("receive count beyond store");

  a_rx_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_i.cmd == sfd_pkg::CMD_RX)) |=> out_valid_q)
    else $error("received byte gave no result beat");

  a_copy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> !in_i.ready)
    else $error("input taken during copy sweep");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

import sfd_pkg::*;

// receive side of the deframer
typedef enum logic [1:0] {
  PH_HUNT,
  PH_HEAD,
  PH_BODY
} rx_phase_e;

// result receiver stall patterns
typedef enum logic [1:0] {
  RDY_ALWAYS,
  RDY_MOSTLY,
  RDY_RARELY,
  RDY_PERIODIC
} stall_mode_e;

typedef struct packed {
  logic [7:0]  tx_byte;
  logic        tx_from_store;
  logic        tx_done;
  rx_event_e   rx_event;
  logic [8:0]  rx_fill;
  loop_event_e loop_event;
} reply_t;

// predicts the reply to each accepted beat and checks replies in order
class deframer_sb;
  logic [7:0]  rx_mem [StoreBytes];
  logic [7:0]  tx_mem [StoreBytes];
  rx_phase_e   phase;
  int unsigned rx_cnt;
  int unsigned tx_cnt;
  int unsigned tx_len;
  logic [7:0]  start_reg;
  logic [7:0]  pad_reg;
  reply_t      pending_replies [$];
  int unsigned errors;

  function new();
    phase     = PH_HUNT;
    rx_cnt    = 0;
    tx_cnt    = 0;
    tx_len    = 0;
    start_reg = '0;
    pad_reg   = '0;
    errors    = 0;
  endfunction

  function void set_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    case (idx)
      CFG_START_BYTE: start_reg = val;
      CFG_PAD_BYTE:   pad_reg = val;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return pending_replies.size();
  endfunction

  // work out the reply to one accepted input beat
  function void note_beat(cmd_e c, logic [7:0] b);
    reply_t      r;
    int unsigned len;
    logic [15:0] mark;
    r = '0;
    if (c == CMD_RX) begin
      if (rx_cnt >= StoreBytes) begin
        r.rx_event = RXEV_DROPPED;
      end else begin
        rx_mem[rx_cnt] = b;
        rx_cnt++;
        case (phase)
          PH_HUNT: begin
            if (rx_mem[0] != start_reg) begin
              rx_cnt     = 0;
              r.rx_event = RXEV_RESYNC;
            end else begin
              phase = PH_HEAD;
            end
          end
          PH_HEAD: begin
            if (rx_cnt == HeaderBytes) begin
              if ((rx_mem[0] ^ rx_mem[2] ^ rx_mem[3]) != rx_mem[1]) begin
                rx_cnt     = 0;
                phase      = PH_HUNT;
                r.rx_event = RXEV_CSUM;
              end else begin
                phase      = PH_BODY;
                r.rx_event = RXEV_HDR_OK;
              end
            end else if (rx_cnt > HeaderBytes) begin
              rx_cnt     = 0;
              phase      = PH_HUNT;
              r.rx_event = RXEV_OVERFLOW;
            end
          end
          default: begin
            len = 32'({rx_mem[3], rx_mem[2]});
            if (rx_cnt == len) begin
              // loopback test on bytes 4-5, refused while still sending
              mark = {rx_mem[5], rx_mem[4]};
              if (mark == LoopMark) begin
                if (tx_cnt < tx_len) begin
                  r.loop_event = LOOP_REFUSED;
                end else begin
                  if (len > StoreBytes) len = StoreBytes;
                  for (int i = 0; i < len; i++) tx_mem[i] = rx_mem[i];
                  tx_cnt       = 0;
                  tx_len       = len;
                  r.loop_event = LOOP_STARTED;
                end
              end
              phase      = PH_HUNT;
              rx_cnt     = 0;
              r.rx_event = RXEV_COMPLETE;
            end
            if (rx_cnt >= StoreBytes) begin
              rx_cnt     = 0;
              phase      = PH_HUNT;
              r.rx_event = RXEV_OVERFLOW;
            end
          end
        endcase
      end
    end else begin
      if (tx_cnt >= tx_len) begin
        r.tx_byte = pad_reg;
      end else begin
        r.tx_byte       = tx_mem[tx_cnt];
        r.tx_from_store = 1'b1;
        tx_cnt++;
      end
      r.tx_done = (tx_cnt == tx_len);
    end
    r.rx_fill = rx_cnt[8:0];
    pending_replies.push_back(r);
  endfunction

  function void cmp(string what, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // compare one accepted reply with the oldest prediction
  function void check_reply(reply_t got);
    reply_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: reply beat with nothing pending, actual %0h", $time, got);
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    cmp("tx_byte", 9'(want.tx_byte), 9'(got.tx_byte));
    cmp("tx_from_store", 9'(want.tx_from_store), 9'(got.tx_from_store));
    cmp("tx_done", 9'(want.tx_done), 9'(got.tx_done));
    cmp("rx_event", 9'(want.rx_event), 9'(got.rx_event));
    cmp("rx_fill", want.rx_fill, got.rx_fill);
    cmp("loop_event", 9'(want.loop_event), 9'(got.loop_event));
  endfunction
endclass

module tb;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  logic clk_i;
  logic rst_ni;

  sfd_in_if             in_if ();
  sfd_out_if #(.CntW(9)) out_if ();
  sfd_cfg_if            cfg_if ();

  spi_frame_deframer_loopback u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  deframer_sb  sb = new();
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  bit          mix_tx = 0;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // one input beat, sent in bursts with random gaps between them
  task automatic send_beat(cmd_e c, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      if ($urandom_range(9) == 0) gap = $urandom_range(40, 7);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(60, 1);
    end
    burst_left--;
    in_if.valid   <= 1'b1;
    in_if.cmd     <= c;
    in_if.rx_byte <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_beat(c, b);
    items_sent++;
  endtask

  // hold the sender until every reply is back, then let the block settle
  task automatic drain(int unsigned settle);
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // header, then body; only n_bytes of the frame are sent
  task automatic send_frame(int unsigned len, bit loop, bit bad_csum, int unsigned n_bytes);
    logic [7:0] hdr [4];
    logic [7:0] b;
    hdr[0] = sb.start_reg;
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    hdr[1] = hdr[0] ^ hdr[2] ^ hdr[3];
    if (bad_csum) hdr[1] = hdr[1] ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < n_bytes; i++) begin
      if (i < HeaderBytes) b = hdr[i];
      else if (loop && i == 4) b = LoopMark[7:0];
      else if (loop && i == 5) b = LoopMark[15:8];
      else b = 8'($urandom);
      if (mix_tx && $urandom_range(4) == 0) send_beat(CMD_TX, 8'($urandom));
      send_beat(CMD_RX, b);
    end
  endtask

  function automatic int unsigned frame_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 85) return $urandom_range(24, 6);
    if (p < 97) return $urandom_range(255, 25);
    return StoreBytes;
  endfunction

  // result receiver with its own stall pattern
  initial begin : result_sink
    int unsigned cyc;
    stall_mode_e mode;
    reply_t      got;
    cyc  = 0;
    mode = RDY_ALWAYS;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.tx_byte       = out_if.tx_byte;
        got.tx_from_store = out_if.tx_from_store;
        got.tx_done       = out_if.tx_done;
        got.rx_event      = rx_event_e'(out_if.rx_event);
        got.rx_fill       = out_if.rx_fill;
        got.loop_event    = loop_event_e'(out_if.loop_event);
        sb.check_reply(got);
      end
      if (cyc % 97 == 0) mode = stall_mode_e'($urandom_range(3));
      cyc++;
      case (mode)
        RDY_ALWAYS:   out_if.ready <= 1'b1;
        RDY_MOSTLY:   out_if.ready <= ($urandom_range(9) < 7);
        RDY_RARELY:   out_if.ready <= ($urandom_range(3) == 0);
        default:      out_if.ready <= (cyc % 5 != 0);
      endcase
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned pick;
    int unsigned len;
    int unsigned target;
    in_if.valid   <= 1'b0;
    in_if.cmd     <= CMD_RX;
    in_if.rx_byte <= 8'h00;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CFG_START_BYTE;
    cfg_if.data   <= 8'h00;
    rst_ni        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle transmitter straight after reset sends the reset pad
    send_beat(CMD_TX, 8'hFF);
    drain(8);
    write_reg(CFG_START_BYTE, 8'hFF);
    write_reg(CFG_PAD_BYTE, 8'hFF);
    // a wrong first byte, then a loopback frame
    send_beat(CMD_RX, 8'h00);
    send_frame(6, 1'b1, 1'b0, 6);
    repeat (6) send_beat(CMD_TX, 8'h00);
    // checksum failure
    send_frame(6, 1'b0, 1'b1, 4);
    // short frame: byte 5 still holds the marker from the earlier frame
    send_frame(5, 1'b1, 1'b0, 5);
    // loopback while the short frame is still going out
    send_frame(6, 1'b1, 1'b0, 6);

    // random phases, each with its own register setting
    for (int p = 0; p < 4; p++) begin
      drain(300);
      case (p)
        0: begin
          write_reg(CFG_START_BYTE, 8'h00);
          write_reg(CFG_PAD_BYTE, 8'hFF);
        end
        1: begin
          write_reg(CFG_START_BYTE, 8'hFF);
          write_reg(CFG_PAD_BYTE, 8'h00);
          write_reg(CFG_SPARE, 8'($urandom));
        end
        default: begin
          write_reg(CFG_START_BYTE, 8'($urandom));
          write_reg(CFG_PAD_BYTE, 8'($urandom));
        end
      endcase
      mix_tx = 1'b1;
      target = items_sent + 450;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          // well-formed frame, loopback or not
          len = frame_len();
          send_frame(len, 1'($urandom), 1'b0, len);
        end else if (pick < 58) begin
          // bad checksum, maybe trailed by stray bytes
          send_frame(frame_len(), 1'($urandom), 1'b1, $urandom_range(7, 4));
        end else if (pick < 66) begin
          // line noise
          repeat ($urandom_range(6, 1)) send_beat(CMD_RX, 8'($urandom));
        end else if (pick < 71) begin
          // short frame, loopback test reads an older byte 5
          send_frame(5, 1'($urandom), 1'b0, 5);
        end else if (pick < 72) begin
          // length never reached: body runs into the end of the store
          len = $urandom_range(1) ? $urandom_range(4, 0) : $urandom_range(65535, 257);
          send_frame(len, 1'b0, 1'b0, StoreBytes);
        end else if (pick < 80) begin
          // truncated frame, the next bytes land in its body
          len = $urandom_range(24, 6);
          send_frame(len, 1'($urandom), 1'b0, $urandom_range(len - 1, 4));
        end else if (pick < 98) begin
          // run of transmit slots
          repeat ($urandom_range(20, 1)) send_beat(CMD_TX, 8'($urandom));
        end else begin
          drain(0);
        end
      end
    end

    // wait for the last replies, then for the block to go quiet
    drain(300);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(64'd60_000_000);
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sfd_pkg.sv
design/sfd_if.sv
design/spi_frame_deframer_loopback.sv
tb/sv/tb.sv
